// ----- sv/u8dec_pkg.sv -----
// ---------------------------------------------------------------------------
// u8dec_pkg: shared types and constants of the UTF-8 stream decoder
// Byte classes, result status codes and the queue entry passed from the
// front (classifier) to the back (sequence decoder).
// ---------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

   localparam int BYTE_W        = 8;
   localparam int CP_W          = 31;
   localparam int LEN_W         = 3;
   localparam int STATUS_W      = 2;
   localparam int MAX_SEQ_BYTES = 6;   // longest sequence taken, 4..6
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [1:0] {
      CLS_ASCII    = 2'd0,
      CLS_CONT     = 2'd1,
      CLS_LEAD     = 2'd2,
      CLS_BAD_LEAD = 2'd3
   } cls_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_STRAY    = 2'd1,
      STATUS_BAD_LEAD = 2'd2,
      STATUS_BAD_CONT = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      cls_type           cls;
      logic [LEN_W-1:0]  lead_len;   // sequence length announced by a lead
   } entry_type;

endpackage

`default_nettype wire

// ----- sv/u8dec_front.sv -----
// ---------------------------------------------------------------------------
// u8dec_front: byte classifier
// Accepts raw bytes and tags each one as ASCII, continuation, valid lead
// (with its announced length) or invalid lead before it enters the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module u8dec_front (
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [u8dec_pkg::BYTE_W-1:0]   req_byte_in,
   output logic                                push_valid,
   output u8dec_pkg::entry_type                push_entry,
   input  wire logic                           push_ready
);

   u8dec_pkg::cls_type             cls;
   logic [u8dec_pkg::LEN_W-1:0]    len;

   always_comb begin
      cls = u8dec_pkg::CLS_LEAD;
      len = '0;
      case (req_byte_in) inside
         [8'h00:8'h7F]: cls = u8dec_pkg::CLS_ASCII;
         [8'h80:8'hBF]: cls = u8dec_pkg::CLS_CONT;
         [8'hC0:8'hDF]: len = 3'd2;
         [8'hE0:8'hEF]: len = 3'd3;
         [8'hF0:8'hF7]: len = 3'd4;
         [8'hF8:8'hFB]: len = 3'd5;
         [8'hFC:8'hFD]: len = 3'd6;
         default:       cls = u8dec_pkg::CLS_BAD_LEAD;
      endcase
      // demote leads longer than the supported maximum
      if (cls == u8dec_pkg::CLS_LEAD && len > u8dec_pkg::LEN_W'(u8dec_pkg::MAX_SEQ_BYTES)) begin
         cls = u8dec_pkg::CLS_BAD_LEAD;
      end
   end

   assign push_entry.data     = req_byte_in;
   assign push_entry.cls      = cls;
   assign push_entry.lead_len = len;
   assign push_valid          = req_valid;
   assign req_ready           = push_ready;

endmodule

`default_nettype wire

// ----- sv/u8dec_queue.sv -----
// ---------------------------------------------------------------------------
// u8dec_queue: short queue between classifier and decoder
// Register-based FIFO of classified bytes; push and pop in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module u8dec_queue #(
   parameter int DEPTH = u8dec_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire u8dec_pkg::entry_type  push_entry,
   output logic                       push_ready,
   output logic                       pop_valid,
   output u8dec_pkg::entry_type       pop_entry,
   input  wire logic                  pop_ready
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   u8dec_pkg::entry_type  mem_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff,  count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- sv/u8dec_back.sv -----
// ---------------------------------------------------------------------------
// u8dec_back: sequence decoder
// Folds classified bytes into the partial code point and loads the result
// register when a sequence completes or an error is found.
// ---------------------------------------------------------------------------
`default_nettype none

module u8dec_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              pop_valid,
   input  wire u8dec_pkg::entry_type              pop_entry,
   output logic                                   pop_ready,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [u8dec_pkg::CP_W-1:0]             rsp_code_point,
   output logic [u8dec_pkg::LEN_W-1:0]            rsp_seq_length,
   output logic [u8dec_pkg::STATUS_W-1:0]         rsp_status
);

   logic [u8dec_pkg::CP_W-1:0]   partial_ff, partial_in;
   logic [u8dec_pkg::LEN_W-1:0]  remain_ff,  remain_in;
   logic [u8dec_pkg::LEN_W-1:0]  seqlen_ff,  seqlen_in;

   logic                         out_valid_ff, out_valid_in;
   logic [u8dec_pkg::CP_W-1:0]   out_cp_ff,    out_cp_in;
   logic [u8dec_pkg::LEN_W-1:0]  out_len_ff,   out_len_in;
   u8dec_pkg::status_type        out_st_ff,    out_st_in;

   logic                         take;
   logic                         emit;
   logic [u8dec_pkg::CP_W-1:0]   emit_cp;
   logic [u8dec_pkg::LEN_W-1:0]  emit_len;
   u8dec_pkg::status_type        emit_st;
   logic [u8dec_pkg::CP_W-1:0]   shifted;
   logic [u8dec_pkg::BYTE_W-1:0] lead_mask;

   // advance whenever the result register is free or being drained
   assign pop_ready = !out_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;

   assign shifted   = {partial_ff[u8dec_pkg::CP_W-7:0], pop_entry.data[5:0]};
   assign lead_mask = 8'h7F >> pop_entry.lead_len;

   always_comb begin
      partial_in = partial_ff;
      remain_in  = remain_ff;
      seqlen_in  = seqlen_ff;
      emit       = 1'b0;
      emit_cp    = '0;
      emit_len   = 3'd1;
      emit_st    = u8dec_pkg::STATUS_OK;
      if (take) begin
         if (remain_ff == '0) begin
            case (pop_entry.cls)
               u8dec_pkg::CLS_ASCII: begin
                  emit    = 1'b1;
                  emit_cp = u8dec_pkg::CP_W'(pop_entry.data);
               end
               u8dec_pkg::CLS_CONT: begin
                  emit    = 1'b1;
                  emit_st = u8dec_pkg::STATUS_STRAY;
               end
               u8dec_pkg::CLS_LEAD: begin
                  partial_in = u8dec_pkg::CP_W'(pop_entry.data & lead_mask);
                  seqlen_in  = pop_entry.lead_len;
                  remain_in  = pop_entry.lead_len - 1'b1;
               end
               default: begin
                  emit    = 1'b1;
                  emit_st = u8dec_pkg::STATUS_BAD_LEAD;
               end
            endcase
         end else if (pop_entry.cls != u8dec_pkg::CLS_CONT) begin
            // drop the sequence, the offending byte is consumed
            emit       = 1'b1;
            emit_st    = u8dec_pkg::STATUS_BAD_CONT;
            emit_len   = seqlen_ff - remain_ff + 1'b1;
            partial_in = '0;
            remain_in  = '0;
            seqlen_in  = '0;
         end else if (remain_ff == 3'd1) begin
            emit       = 1'b1;
            emit_cp    = shifted;
            emit_len   = seqlen_ff;
            partial_in = '0;
            remain_in  = '0;
            seqlen_in  = '0;
         end else begin
            partial_in = shifted;
            remain_in  = remain_ff - 1'b1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_cp_in    = out_cp_ff;
      out_len_in   = out_len_ff;
      out_st_in    = out_st_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_cp_in    = emit_cp;
         out_len_in   = emit_len;
         out_st_in    = emit_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         remain_ff    <= '0;
         seqlen_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         partial_ff   <= partial_in;
         remain_ff    <= remain_in;
         seqlen_ff    <= seqlen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_cp_ff  <= out_cp_in;
      out_len_ff <= out_len_in;
      out_st_ff  <= out_st_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;
   assign rsp_seq_length = out_len_ff;
   assign rsp_status     = out_st_ff;

endmodule

`default_nettype wire

// ----- sv/utf8_stream_decoder_top.sv -----
// Path: a byte is queued first, then any result it ends is registered.
// Throughput: one byte per cycle, sustained while the result side takes beats.
// The decoder state and the result register set the pace of one byte a cycle.
// Reset (synchronous): empties the queue, drops any pending result and
// returns the decoder to idle; no clearing pass, bytes are taken right after.
// ---------------------------------------------------------------------------
// utf8_stream_decoder_top: extended UTF-8 stream decoder
// Classifier front, short queue, and sequence decoder back with a result
// register; one result per completed sequence or error.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_top #(
   parameter int QUEUE_DEPTH = u8dec_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [u8dec_pkg::BYTE_W-1:0]      req_byte_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [u8dec_pkg::CP_W-1:0]             rsp_code_point,
   output logic [u8dec_pkg::LEN_W-1:0]            rsp_seq_length,
   output logic [u8dec_pkg::STATUS_W-1:0]         rsp_status
);

   logic                  push_valid, push_ready;
   u8dec_pkg::entry_type  push_entry;
   logic                  pop_valid, pop_ready;
   u8dec_pkg::entry_type  pop_entry;

   u8dec_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .push_ready  (push_ready)
   );

   u8dec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   u8dec_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_entry      (pop_entry),
      .pop_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_seq_length (rsp_seq_length),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

// ----- sv/u8dec_checker.sv -----
// ---------------------------------------------------------------------------
// u8dec_checker: port-level checks of the UTF-8 stream decoder
// Watches the result channel for stable beats and consistent fields.
// ---------------------------------------------------------------------------
`default_nettype none

module u8dec_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [u8dec_pkg::CP_W-1:0]        rsp_code_point,
   input wire logic [u8dec_pkg::LEN_W-1:0]       rsp_seq_length,
   input wire logic [u8dec_pkg::STATUS_W-1:0]    rsp_status
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_seq_length) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   a_err_zero_cp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != u8dec_pkg::STATUS_OK |-> rsp_code_point == '0)
      else $error("error result carries a code point");

   a_single_byte_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == u8dec_pkg::STATUS_STRAY
         || rsp_status == u8dec_pkg::STATUS_BAD_LEAD) |-> rsp_seq_length == 3'd1)
      else $error("lead-position error with length other than one");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_seq_length != '0
         && rsp_seq_length <= u8dec_pkg::LEN_W'(u8dec_pkg::MAX_SEQ_BYTES))
      else $error("sequence length out of range");

   a_ascii_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == u8dec_pkg::STATUS_OK && rsp_seq_length == 3'd1
         |-> rsp_code_point < 31'd128)
      else $error("one-byte result above the ASCII range");

endmodule

bind utf8_stream_decoder_top u8dec_checker u_u8dec_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_code_point (rsp_code_point),
   .rsp_seq_length (rsp_seq_length),
   .rsp_status     (rsp_status)
);

`default_nettype wire

// ----- dv/utf8_stream_decoder_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_stream_decoder_checker: result predictor and scoreboard
// Watches the byte and result channels of the decoder and keeps its own
// decoder state. Each accepted byte may produce an expected code point.
// Each accepted result is checked against the oldest expected one.
// ---------------------------------------------------------------------------

module utf8_stream_decoder_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [u8dec_pkg::BYTE_W-1:0]         req_byte_in,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [u8dec_pkg::CP_W-1:0]           rsp_code_point,
   input  logic [u8dec_pkg::LEN_W-1:0]          rsp_seq_length,
   input  logic [u8dec_pkg::STATUS_W-1:0]       rsp_status,
   output int                                   fail_count,
   output int                                   pending_count,
   output int                                   byte_count,
   output int                                   result_count,
   output int                                   error_count
);

   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [u8dec_pkg::CP_W-1:0]  code_point;
      logic [u8dec_pkg::LEN_W-1:0] seq_length;
      u8dec_pkg::status_type       status;
   } decoded_char_type;

   decoded_char_type              expected_chars[$];
   logic [u8dec_pkg::CP_W-1:0]    acc_cp;
   logic [u8dec_pkg::LEN_W-1:0]   cont_left;
   logic [u8dec_pkg::LEN_W-1:0]   cur_len;
   int                            fails;
   int                            n_bytes;
   int                            n_results;
   int                            n_errors;

   task automatic push_char(input logic [u8dec_pkg::CP_W-1:0] cp,
                            input logic [u8dec_pkg::LEN_W-1:0] len,
                            input u8dec_pkg::status_type st);
      decoded_char_type c;
      c.code_point = cp;
      c.seq_length = len;
      c.status     = st;
      expected_chars.push_back(c);
   endtask

   task automatic return_idle();
      acc_cp    = '0;
      cont_left = '0;
      cur_len   = '0;
   endtask

   // Advance the decoder model by one byte.
   task automatic decode_byte(input logic [u8dec_pkg::BYTE_W-1:0] b);
      logic [u8dec_pkg::LEN_W-1:0] n;
      logic [u8dec_pkg::LEN_W-1:0] used;
      if (cont_left == 0) begin
         if (b < 8'h80) begin
            return_idle();
            push_char(u8dec_pkg::CP_W'(b), 3'd1, u8dec_pkg::STATUS_OK);
         end else if (b < 8'hC0) begin
            return_idle();
            push_char('0, 3'd1, u8dec_pkg::STATUS_STRAY);
         end else begin
            n = (b < 8'hE0) ? 3'd2 : (b < 8'hF0) ? 3'd3 : (b < 8'hF8) ? 3'd4 :
                (b < 8'hFC) ? 3'd5 : (b < 8'hFE) ? 3'd6 : 3'd0;
            if (n == 0 || int'(n) > u8dec_pkg::MAX_SEQ_BYTES) begin
               return_idle();
               push_char('0, 3'd1, u8dec_pkg::STATUS_BAD_LEAD);
            end else begin
               // lead of n bytes carries 7 - n payload bits
               acc_cp    = u8dec_pkg::CP_W'(b)
                           & ((u8dec_pkg::CP_W'(1) << (3'd7 - n)) - u8dec_pkg::CP_W'(1));
               cur_len   = n;
               cont_left = n - 3'd1;
            end
         end
      end else if (b[7:6] != 2'b10) begin
         used = cur_len - cont_left + 3'd1;
         return_idle();
         push_char('0, used, u8dec_pkg::STATUS_BAD_CONT);
      end else begin
         acc_cp    = {acc_cp[u8dec_pkg::CP_W-7:0], b[5:0]};
         cont_left = cont_left - 3'd1;
         if (cont_left == 0) begin
            push_char(acc_cp, cur_len, u8dec_pkg::STATUS_OK);
            return_idle();
         end
      end
   endtask

   task automatic report_fail(input string what);
      fails++;
      if (fails <= REPORT_MAX)
         $display("[%0t] MISMATCH %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      decoded_char_type exp_c;
      if (reset) begin
         expected_chars.delete();
         return_idle();
         fails     = 0;
         n_bytes   = 0;
         n_results = 0;
         n_errors  = 0;
      end else begin
         if (req_valid && req_ready) begin
            n_bytes++;
            decode_byte(req_byte_in);
         end
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (rsp_status != u8dec_pkg::STATUS_OK)
               n_errors++;
            if (expected_chars.size() == 0) begin
               report_fail($sformatf("unexpected beat cp=%h len=%0d status=%0d",
                                     rsp_code_point, rsp_seq_length, rsp_status));
            end else begin
               exp_c = expected_chars.pop_front();
               if (rsp_code_point !== exp_c.code_point ||
                   rsp_seq_length !== exp_c.seq_length ||
                   rsp_status !== exp_c.status)
                  report_fail($sformatf(
                     "exp cp=%h len=%0d status=%s, got cp=%h len=%0d status=%0d",
                     exp_c.code_point, exp_c.seq_length, exp_c.status.name(),
                     rsp_code_point, rsp_seq_length, rsp_status));
            end
         end
      end
      fail_count    <= fails;
      pending_count <= expected_chars.size();
      byte_count    <= n_bytes;
      result_count  <= n_results;
      error_count   <= n_errors;
   end

endmodule

// ----- dv/utf8_stream_decoder_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_stream_decoder_top_tb: testbench of the UTF-8 stream decoder
// Feeds directed and random byte streams (well-formed sequences of every
// length, broken sequences and noise) with random gaps on both channels and
// a long output stall; the checker predicts and compares every result.
// ---------------------------------------------------------------------------

module utf8_stream_decoder_top_tb;

   localparam int RANDOM_BYTES = 1900;
   localparam int IDLE_PCT     = 37;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_START   = 500;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 8;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic [u8dec_pkg::BYTE_W-1:0]         req_byte_in;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [u8dec_pkg::CP_W-1:0]           rsp_code_point;
   logic [u8dec_pkg::LEN_W-1:0]          rsp_seq_length;
   logic [u8dec_pkg::STATUS_W-1:0]       rsp_status;

   int fail_count;
   int pending_count;
   int byte_count;
   int result_count;
   int error_count;
   int quiet_cycles;
   bit gapless;

   utf8_stream_decoder_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_in    (req_byte_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_seq_length (rsp_seq_length),
      .rsp_status     (rsp_status)
   );

   utf8_stream_decoder_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_in    (req_byte_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_seq_length (rsp_seq_length),
      .rsp_status     (rsp_status),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .byte_count     (byte_count),
      .result_count   (result_count),
      .error_count    (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one byte and hold it until the beat is taken.
   task automatic send_byte(input logic [u8dec_pkg::BYTE_W-1:0] b);
      while (!gapless && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [u8dec_pkg::BYTE_W-1:0] make_lead(input int n);
      logic [u8dec_pkg::BYTE_W-1:0] prefix;
      prefix = 8'hFF << (8 - n);
      return prefix | (u8dec_pkg::BYTE_W'($urandom) & ~prefix & ~(8'h80 >> n));
   endfunction

   // Send a sequence of n bytes, cut off after n_cont continuations when broken.
   task automatic send_sequence(input int n, input bit broken, input int n_cont,
                                output int sent);
      logic [u8dec_pkg::BYTE_W-1:0] b;
      sent = 0;
      if (n == 1) begin
         send_byte(u8dec_pkg::BYTE_W'($urandom_range(0, 127)));
         sent = 1;
      end else begin
         send_byte(make_lead(n));
         sent = 1;
         for (int i = 0; i < (broken ? n_cont : n - 1); i++) begin
            send_byte(8'h80 | u8dec_pkg::BYTE_W'($urandom_range(0, 63)));
            sent++;
         end
         if (broken) begin
            b = u8dec_pkg::BYTE_W'($urandom);
            if (b[7:6] == 2'b10)
               b[6] = 1'b1;
            send_byte(b);
            sent++;
         end
      end
   endtask

   // Receiver: random stalls, plus one long hold-off while bytes keep coming.
   initial begin
      int cycle_cnt;
      cycle_cnt = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (cycle_cnt >= HOLD_START && cycle_cnt < HOLD_START + HOLD_CYCLES)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= gapless || ($urandom_range(0, 99) >= IDLE_PCT);
         cycle_cnt++;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] no beat for %0d cycles", $realtime, quiet_cycles);
         $display("utf8_stream_decoder_top_tb failed");
         $finish;
      end
   end

   initial begin
      logic [u8dec_pkg::BYTE_W-1:0] directed[$] = '{
         8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF,
         8'hC2, 8'hA9,
         8'hE2, 8'h82, 8'hAC,
         8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
         8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
         8'hE2, 8'h41,
         8'hC3, 8'hC0
      };
      int sent_total;
      int sent;
      int pick;
      int n;
      gapless      = 1'b0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_byte_in <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_byte(directed[i]);

      sent_total = 0;
      while (sent_total < RANDOM_BYTES) begin
         gapless = (sent_total >= 900 && sent_total < 1200);
         pick = $urandom_range(0, 99);
         n    = $urandom_range(1, u8dec_pkg::MAX_SEQ_BYTES);
         if (pick < 70) begin
            send_sequence(n, 1'b0, 0, sent);
         end else if (pick < 85) begin
            n = $urandom_range(2, u8dec_pkg::MAX_SEQ_BYTES);
            send_sequence(n, 1'b1, $urandom_range(0, n - 2), sent);
         end else begin
            send_byte(u8dec_pkg::BYTE_W'($urandom));
            sent = 1;
         end
         sent_total += sent;
      end
      gapless    = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d bytes and %0d results (%0d errors), all lead lengths,",
               byte_count, result_count, error_count);
      $display("broken sequences, noise bytes and a %0d-cycle output hold-off.",
               HOLD_CYCLES);
      if (pending_count != 0)
         $display("%0d expected results never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0)
         $display("utf8_stream_decoder_top_tb passed");
      else
         $display("utf8_stream_decoder_top_tb failed");
      $finish;
   end

endmodule

// ----- utf8_stream_decoder_top.f -----
sv/u8dec_pkg.sv
sv/u8dec_front.sv
sv/u8dec_queue.sv
sv/u8dec_back.sv
sv/utf8_stream_decoder_top.sv
sv/u8dec_checker.sv
dv/utf8_stream_decoder_checker.sv
dv/utf8_stream_decoder_top_tb.sv
